/* rtl/c2s_pkg.sv */
// ----------------------------------------------------------------------------
// c2s_pkg
// shared widths and constants of the cube to sphere mapping pipeline
// ----------------------------------------------------------------------------
package c2s_pkg;

    localparam int COORD_W  = 24;              // signed coordinate width
    localparam int FRAC     = 22;              // fraction bits of normalized values
    localparam int RAD_W    = 23;              // radius register width
    localparam int W_W      = FRAC + 1;        // normalized value, up to 1.0
    localparam int RADIC_W  = FRAC + 2;        // radicand with headroom
    localparam int SQV_W    = RADIC_W + FRAC;  // radicand scaled for the root
    localparam int ROOT_W   = FRAC + 1;        // root, up to 1.0

    localparam int DIV_STG  = W_W;             // one quotient bit per stage
    localparam int RAD_STG  = 4;               // square, cross, third, sum
    localparam int SQRT_STG = ROOT_W;          // one root bit per stage
    localparam int LAT      = 1 + DIV_STG + RAD_STG + SQRT_STG + 3;

    // floor(p / 3) == (p * REC3) >> REC3_SH for p below 2^24
    localparam int             REC3_SH = 25;
    localparam logic [23:0]    REC3    = 24'd11184811;

    localparam logic [RAD_W-1:0]   RADIUS_RST = RAD_W'(1024);
    localparam logic [RADIC_W-1:0] FIX_ONE    = RADIC_W'(1) << FRAC;

    typedef logic [2:0][W_W-1:0]     t_w_vec;
    typedef logic [2:0][RADIC_W-1:0] t_arg_vec;

endpackage

/* rtl/c2s_div.sv */
// ----------------------------------------------------------------------------
// c2s_div
// pipelined restoring divider: quotient = (mag << FRAC) / radius, mag <= radius
// ----------------------------------------------------------------------------
module c2s_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [c2s_pkg::RAD_W-1:0]     i_mag,
    input  logic [c2s_pkg::RAD_W-1:0]     i_radius,
    output logic [c2s_pkg::W_W-1:0]       o_quot
);

    logic [c2s_pkg::RAD_W-1:0] r_rem [c2s_pkg::DIV_STG];
    logic [c2s_pkg::W_W-1:0]   r_q   [c2s_pkg::DIV_STG];
    logic [c2s_pkg::RAD_W-1:0] n_rem [c2s_pkg::DIV_STG];
    logic [c2s_pkg::W_W-1:0]   n_q   [c2s_pkg::DIV_STG];

    always_comb begin
        logic [c2s_pkg::RAD_W:0]   t;
        logic [c2s_pkg::W_W-1:0]   qs;
        logic                      b;
        for (int k = 0; k < c2s_pkg::DIV_STG; k++) begin
            // first step sees mag itself, later steps shift in a zero
            if (k == 0) begin
                t  = {1'b0, i_mag};
                qs = '0;
            end else begin
                t  = {r_rem[k-1], 1'b0};
                qs = r_q[k-1];
            end
            b        = (t >= {1'b0, i_radius});
            n_rem[k] = b ? c2s_pkg::RAD_W'(t - {1'b0, i_radius}) : t[c2s_pkg::RAD_W-1:0];
            n_q[k]   = {qs[c2s_pkg::W_W-2:0], b};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < c2s_pkg::DIV_STG; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
            end
        end
    end

    assign o_quot = r_q[c2s_pkg::DIV_STG-1];

endmodule

/* rtl/c2s_radicand.sv */
// ----------------------------------------------------------------------------
// c2s_radicand
// per axis radicand 1 - a^2/2 - b^2/2 + a^2*b^2/3 over four stages
// ----------------------------------------------------------------------------
module c2s_radicand (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  c2s_pkg::t_w_vec      i_w,
    output c2s_pkg::t_arg_vec    o_arg
);

    localparam int PW = 2 * c2s_pkg::W_W;

    logic [2:0][c2s_pkg::W_W-1:0]     r_sq;
    logic [2:0][c2s_pkg::W_W-1:0]     r_p;
    logic [2:0][c2s_pkg::RADIC_W-1:0] r_hs1;
    logic [2:0][c2s_pkg::W_W-1:0]     r_p3;
    logic [2:0][c2s_pkg::RADIC_W-1:0] r_hs2;
    logic [2:0][c2s_pkg::RADIC_W-1:0] r_arg;

    always_ff @(posedge i_clk) begin
        logic [PW-1:0]      prod;
        logic [PW:0]        prod3;
        logic [c2s_pkg::RADIC_W:0] sum;
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                prod    = PW'(i_w[i]) * PW'(i_w[i]);
                r_sq[i] <= prod[c2s_pkg::FRAC +: c2s_pkg::W_W];

                prod    = PW'(r_sq[(i+1)%3]) * PW'(r_sq[(i+2)%3]);
                r_p[i]  <= prod[c2s_pkg::FRAC +: c2s_pkg::W_W];
                r_hs1[i] <= c2s_pkg::RADIC_W'(r_sq[(i+1)%3] >> 1)
                          + c2s_pkg::RADIC_W'(r_sq[(i+2)%3] >> 1);

                // divide by three through the reciprocal
                prod3   = (PW+1)'(r_p[i]) * (PW+1)'(c2s_pkg::REC3);
                r_p3[i] <= c2s_pkg::W_W'(prod3[PW:c2s_pkg::REC3_SH]);
                r_hs2[i] <= r_hs1[i];

                sum      = (c2s_pkg::RADIC_W+1)'(c2s_pkg::FIX_ONE)
                         + (c2s_pkg::RADIC_W+1)'(r_p3[i])
                         - (c2s_pkg::RADIC_W+1)'(r_hs2[i]);
                r_arg[i] <= sum[c2s_pkg::RADIC_W-1:0];
            end
        end
    end

    assign o_arg = r_arg;

endmodule

/* rtl/c2s_sqrt.sv */
// ----------------------------------------------------------------------------
// c2s_sqrt
// pipelined digit by digit integer square root of (arg << FRAC)
// ----------------------------------------------------------------------------
module c2s_sqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [c2s_pkg::RADIC_W-1:0]   i_arg,
    output logic [c2s_pkg::ROOT_W-1:0]    o_root
);

    logic [c2s_pkg::SQV_W-1:0]  r_rem  [c2s_pkg::SQRT_STG];
    logic [c2s_pkg::ROOT_W-1:0] r_root [c2s_pkg::SQRT_STG];
    logic [c2s_pkg::SQV_W-1:0]  n_rem  [c2s_pkg::SQRT_STG];
    logic [c2s_pkg::ROOT_W-1:0] n_root [c2s_pkg::SQRT_STG];

    always_comb begin
        logic [c2s_pkg::SQV_W:0]    t;
        logic [c2s_pkg::SQV_W-1:0]  rs;
        logic [c2s_pkg::ROOT_W-1:0] qs;
        logic                       b;
        for (int k = 0; k < c2s_pkg::SQRT_STG; k++) begin
            if (k == 0) begin
                rs = {i_arg, c2s_pkg::FRAC'(0)};
                qs = '0;
            end else begin
                rs = r_rem[k-1];
                qs = r_root[k-1];
            end
            // (root + 2^i)^2 - root^2
            t = ((c2s_pkg::SQV_W+1)'(qs) << (c2s_pkg::ROOT_W - k))
              + ((c2s_pkg::SQV_W+1)'(1) << (2 * (c2s_pkg::ROOT_W - 1 - k)));
            b         = ({1'b0, rs} >= t);
            n_rem[k]  = b ? c2s_pkg::SQV_W'({1'b0, rs} - t) : rs;
            n_root[k] = qs | (b ? (c2s_pkg::ROOT_W'(1) << (c2s_pkg::ROOT_W - 1 - k)) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < c2s_pkg::SQRT_STG; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
        end
    end

    assign o_root = r_root[c2s_pkg::SQRT_STG-1];

endmodule

/* rtl/cube_to_sphere_mapper_core.sv */
// throughput: one point per cycle, limited only by output stall
// the whole pipeline advances together; it holds while a result is stalled
// reset clears all stage valid bits and loads the radius with 1024
// payload registers are not reset
// ----------------------------------------------------------------------------
// cube_to_sphere_mapper_core
// maps a point on a cube surface onto the sphere of the configured radius
// ----------------------------------------------------------------------------
module cube_to_sphere_mapper_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [c2s_pkg::RAD_W-1:0]           i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [c2s_pkg::COORD_W-1:0]  i_cube_x,
    input  logic signed [c2s_pkg::COORD_W-1:0]  i_cube_y,
    input  logic signed [c2s_pkg::COORD_W-1:0]  i_cube_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [c2s_pkg::COORD_W-1:0]  o_sphere_x,
    output logic signed [c2s_pkg::COORD_W-1:0]  o_sphere_y,
    output logic signed [c2s_pkg::COORD_W-1:0]  o_sphere_z,
    output logic                                o_was_clamped
);

    localparam int L  = c2s_pkg::LAT;
    localparam int WD = c2s_pkg::RAD_STG + c2s_pkg::SQRT_STG;
    localparam int CW = c2s_pkg::COORD_W;
    localparam int MW = c2s_pkg::W_W + c2s_pkg::RAD_W;

    logic [c2s_pkg::RAD_W-1:0] r_radius;
    logic [c2s_pkg::RAD_W-1:0] eff_radius;
    logic [L-1:0]              r_vld;
    logic                      adv;

    logic [2:0][c2s_pkg::RAD_W-1:0] r_mag;
    logic [3:0]                     r_side [L-1];
    c2s_pkg::t_w_vec                div_w;
    c2s_pkg::t_w_vec                r_wd [WD];
    c2s_pkg::t_arg_vec              arg;
    logic [2:0][c2s_pkg::ROOT_W-1:0] root;
    logic [2:0][c2s_pkg::W_W-1:0]   r_u;
    logic [2:0][c2s_pkg::RAD_W-1:0] r_om;
    logic [2:0][CW-1:0]             r_out;
    logic                           r_clamp_o;
    logic [CW-1:0]                  in_c [3];

    assign eff_radius = (r_radius == '0) ? c2s_pkg::RAD_W'(1) : r_radius;
    assign adv     = !r_vld[L-1] || !i_stall;
    assign o_stall = !adv;
    assign in_c[0] = i_cube_x;
    assign in_c[1] = i_cube_y;
    assign in_c[2] = i_cube_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= c2s_pkg::RADIUS_RST;
            r_vld    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_radius <= i_cfg_wdata;
            end
            if (adv) begin
                r_vld <= {r_vld[L-2:0], i_valid};
            end
        end
    end

    // input stage: sign split and clamp to the radius
    always_ff @(posedge i_clk) begin
        logic [CW-1:0] a;
        logic [2:0]    ng;
        logic          cl;
        if (adv) begin
            cl = 1'b0;
            for (int i = 0; i < 3; i++) begin
                ng[i] = in_c[i][CW-1];
                a     = ng[i] ? CW'(-in_c[i]) : in_c[i];
                if (a > CW'(eff_radius)) begin
                    r_mag[i] <= eff_radius;
                    cl       = 1'b1;
                end else begin
                    r_mag[i] <= c2s_pkg::RAD_W'(a);
                end
            end
            r_side[0] <= {cl, ng};
            for (int k = 1; k < L - 1; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        c2s_div u_div (
            .i_clk    (i_clk),
            .i_en     (adv),
            .i_mag    (r_mag[g]),
            .i_radius (eff_radius),
            .o_quot   (div_w[g])
        );
        c2s_sqrt u_sqrt (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_arg  (arg[g]),
            .o_root (root[g])
        );
    end

    c2s_radicand u_radicand (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_w   (div_w),
        .o_arg (arg)
    );

    // normalized values wait beside the radicand and root stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_wd[0] <= div_w;
            for (int k = 1; k < WD; k++) begin
                r_wd[k] <= r_wd[k-1];
            end
        end
    end

    // scale by the root, then by the radius, then apply the sign
    always_ff @(posedge i_clk) begin
        logic [MW-1:0] p;
        logic [CW-1:0] m;
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                p       = MW'(r_wd[WD-1][i]) * MW'(root[i]);
                r_u[i]  <= p[c2s_pkg::FRAC +: c2s_pkg::W_W];
                p       = MW'(r_u[i]) * MW'(eff_radius);
                r_om[i] <= p[c2s_pkg::FRAC +: c2s_pkg::RAD_W];
                m        = CW'(r_om[i]);
                r_out[i] <= r_side[L-2][i] ? CW'(-m) : m;
            end
            r_clamp_o <= r_side[L-2][3];
        end
    end

    assign o_valid       = r_vld[L-1];
    assign o_sphere_x    = r_out[0];
    assign o_sphere_y    = r_out[1];
    assign o_sphere_z    = r_out[2];
    assign o_was_clamped = r_clamp_o;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    a_valid_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |=> (o_valid == $past(r_vld[L-2])))
        else $error("result valid lost or invented");

    a_x_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_sphere_x <= $signed({1'b0, eff_radius}))
                  && (o_sphere_x >= -$signed({1'b0, eff_radius}))))
        else $error("x result beyond radius");

    a_z_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_sphere_z <= $signed({1'b0, eff_radius}))
                  && (o_sphere_z >= -$signed({1'b0, eff_radius}))))
        else $error("z result beyond radius");

endmodule
